// ===== rtl/psf_pkg.sv =====
// ----------------------------------------------------------------------------
// psf_pkg
// Shared types, codes and sizes for the packet source filter.
// ----------------------------------------------------------------------------
package psf_pkg;

    localparam int BLOCK4_ENTRIES = 256;
    localparam int BLOCK6_ENTRIES = 256;
    localparam int RATE_ENTRIES   = 1024;

    localparam int B4_AW = (BLOCK4_ENTRIES > 1) ? $clog2(BLOCK4_ENTRIES) : 1;
    localparam int B6_AW = (BLOCK6_ENTRIES > 1) ? $clog2(BLOCK6_ENTRIES) : 1;
    localparam int RT_AW = (RATE_ENTRIES > 1) ? $clog2(RATE_ENTRIES) : 1;
    localparam int RT_CW = $clog2(RATE_ENTRIES + 1);
    localparam int MAX_AW = (B4_AW > B6_AW) ? ((B4_AW > RT_AW) ? B4_AW : RT_AW)
                                             : ((B6_AW > RT_AW) ? B6_AW : RT_AW);
    localparam int SCN_W = MAX_AW + 1;

    localparam int RT_DW = 128;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
    localparam logic [15:0] ETH_MIN    = 16'd14;
    localparam logic [15:0] IP4_MIN    = 16'd34;
    localparam logic [15:0] IP6_MIN    = 16'd54;

    localparam logic [1:0] ACT_ABORT = 2'd0;
    localparam logic [1:0] ACT_DROP  = 2'd1;
    localparam logic [1:0] ACT_PASS  = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    localparam logic [2:0] REQ_PACKET = 3'd0;
    localparam logic [2:0] REQ_ADD4   = 3'd1;
    localparam logic [2:0] REQ_DEL4   = 3'd2;
    localparam logic [2:0] REQ_ADD6   = 3'd3;
    localparam logic [2:0] REQ_DEL6   = 3'd4;
    localparam logic [2:0] REQ_STATS  = 3'd5;

    localparam logic CFG_RATE_LIMIT = 1'b0;
    localparam logic CFG_WINDOW     = 1'b1;

    localparam logic [63:0] WINDOW_RESET = 64'd1000000000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PLAN,
        S_SCAN,
        S_RATE_CALC,
        S_RATE_UPD,
        S_COMMIT
    } state_t;

    typedef enum logic [1:0] {
        TBL_B4,
        TBL_B6,
        TBL_RT
    } table_t;

    typedef struct packed {
        logic capture;
        logic plan;
        logic scan_run;
        logic scan_finish;
        logic rate_start;
        logic rate_calc;
        logic rate_update;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic plan_scan;
        logic scan_done;
        logic need_rate;
        logic scan_rate;
        logic out_busy;
    } stat_t;

endpackage

// ===== rtl/psf_ram.sv =====
// ----------------------------------------------------------------------------
// psf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module psf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/psf_ctrl.sv =====
// ----------------------------------------------------------------------------
// psf_ctrl
// Request sequencer: plan, table scans, rate update and result commit.
// ----------------------------------------------------------------------------
module psf_ctrl
    import psf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t st,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_PLAN;
                end
            end
            S_PLAN:
            begin
                cmd.plan   = 1'b1;
                state_next = st.plan_scan ? S_SCAN : S_COMMIT;
            end
            S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (st.scan_done)
                begin
                    cmd.scan_finish = 1'b1;
                    if (st.scan_rate)
                    begin
                        state_next = S_RATE_CALC;
                    end
                    else if (st.need_rate)
                    begin
                        cmd.rate_start = 1'b1;
                    end
                    else
                    begin
                        state_next = S_COMMIT;
                    end
                end
            end
            S_RATE_CALC:
            begin
                cmd.rate_calc = 1'b1;
                state_next    = S_RATE_UPD;
            end
            S_RATE_UPD:
            begin
                cmd.rate_update = 1'b1;
                state_next      = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (!st.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/psf_dp.sv =====
// ----------------------------------------------------------------------------
// psf_dp
// Datapath: request capture, table RAMs, scan engine, limiter and counters.
// ----------------------------------------------------------------------------
module psf_dp
    import psf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       st,
    input  logic [2:0]  req_type,
    input  logic [15:0] frame_length,
    input  logic [15:0] ethertype,
    input  logic [31:0] source_v4,
    input  logic [63:0] source_v6_high,
    input  logic [63:0] source_v6_low,
    input  logic [63:0] timestamp,
    input  logic [1:0]  query_action,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  verdict,
    output logic [1:0]  status,
    output logic [63:0] action_packets,
    output logic [63:0] action_bytes,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);

    logic [2:0]  req_reg;
    logic [15:0] len_reg;
    logic [15:0] etype_reg;
    logic [31:0] src4_reg;
    logic [63:0] hi_reg, lo_reg, now_reg;
    logic [1:0]  query_reg;

    logic [31:0] rate_limit_reg;
    logic [63:0] window_reg;

    logic [BLOCK4_ENTRIES-1:0] b4_valid_reg, b4_valid_next;
    logic [BLOCK6_ENTRIES-1:0] b6_valid_reg, b6_valid_next;
    logic [RT_CW-1:0]          fill_reg, fill_next;

    logic [63:0] stp_reg [3];
    logic [63:0] stb_reg [3];

    table_t          table_reg, table_next;
    logic [SCN_W-1:0] issue_reg, issue_next;
    logic [SCN_W-1:0] limit_reg, limit_next;
    logic [SCN_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             cmp_pend_reg, cmp_pend_next;
    logic             found_reg, found_next;
    logic [SCN_W-1:0] hit_idx_reg, hit_idx_next;
    logic             free_found_reg, free_found_next;
    logic [SCN_W-1:0] free_idx_reg, free_idx_next;
    logic [31:0]      hit_cnt_reg, hit_cnt_next;
    logic [63:0]      hit_ws_reg, hit_ws_next;

    logic        in_win_reg;
    logic [31:0] inc_reg;
    logic [1:0]  act_reg, act_next;
    logic [1:0]  stat_reg, stat_next;

    logic        out_valid_reg;
    logic [1:0]  verdict_reg, status_reg;
    logic [63:0] pk_reg, by_reg;

    logic [31:0]       b4_rdata;
    logic [127:0]      b6_rdata;
    logic [RT_DW-1:0]  rt_rdata;
    logic              b4_we, b6_we, rt_we;
    logic [RT_AW-1:0]  rt_waddr;
    logic [RT_DW-1:0]  rt_wdata;

    logic is_v4long, is_v6long, plan_b4, plan_b6;
    logic done, match, slot_free;

    logic [1:0]  sel;
    logic [63:0] pk_sum, by_sum;

    assign cfg_ready = 1'b1;

    assign is_v4long = (etype_reg == ETYPE_IPV4) && (len_reg >= IP4_MIN);
    assign is_v6long = (etype_reg == ETYPE_IPV6) && (len_reg >= IP6_MIN);
    assign plan_b4 = ((req_reg == REQ_PACKET) && is_v4long)
                   || (req_reg == REQ_ADD4) || (req_reg == REQ_DEL4);
    assign plan_b6 = ((req_reg == REQ_PACKET) && is_v6long)
                   || (req_reg == REQ_ADD6) || (req_reg == REQ_DEL6);

    assign done = found_reg || ((issue_reg == limit_reg) && !cmp_pend_reg);

    always_comb
    begin
        match     = 1'b0;
        slot_free = 1'b0;
        case (table_reg)
            TBL_B4:
            begin
                match = b4_valid_reg[cmp_idx_reg[B4_AW-1:0]] && (b4_rdata == src4_reg);
                slot_free = !b4_valid_reg[cmp_idx_reg[B4_AW-1:0]];
            end
            TBL_B6:
            begin
                match = b6_valid_reg[cmp_idx_reg[B6_AW-1:0]]
                     && (b6_rdata == {hi_reg, lo_reg});
                slot_free = !b6_valid_reg[cmp_idx_reg[B6_AW-1:0]];
            end
            default:
            begin
                match = (rt_rdata[127:96] == src4_reg);
            end
        endcase
    end

    assign st.plan_scan = plan_b4 || plan_b6;
    assign st.scan_done = done;
    assign st.need_rate = (table_reg == TBL_B4) && (req_reg == REQ_PACKET)
                       && !found_reg && (rate_limit_reg != 32'd0);
    assign st.scan_rate = (table_reg == TBL_RT);
    assign st.out_busy  = out_valid_reg && !out_ready;

    // scan engine
    always_comb
    begin
        table_next      = table_reg;
        issue_next      = issue_reg;
        limit_next      = limit_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_pend_next   = cmp_pend_reg;
        found_next      = found_reg;
        hit_idx_next    = hit_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        hit_cnt_next    = hit_cnt_reg;
        hit_ws_next     = hit_ws_reg;
        if (cmd.plan)
        begin
            table_next      = plan_b6 ? TBL_B6 : TBL_B4;
            limit_next      = plan_b6 ? SCN_W'(BLOCK6_ENTRIES) : SCN_W'(BLOCK4_ENTRIES);
            issue_next      = '0;
            cmp_pend_next   = 1'b0;
            found_next      = 1'b0;
            free_found_next = 1'b0;
        end
        else if (cmd.rate_start)
        begin
            table_next    = TBL_RT;
            limit_next    = SCN_W'(fill_reg);
            issue_next    = '0;
            cmp_pend_next = 1'b0;
            found_next    = 1'b0;
        end
        else if (cmd.scan_run && !done)
        begin
            if (cmp_pend_reg && match)
            begin
                found_next    = 1'b1;
                hit_idx_next  = cmp_idx_reg;
                hit_cnt_next  = rt_rdata[95:64];
                hit_ws_next   = rt_rdata[63:0];
                cmp_pend_next = 1'b0;
            end
            else
            begin
                if (cmp_pend_reg && slot_free && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = cmp_idx_reg;
                end
                if (issue_reg != limit_reg)
                begin
                    issue_next    = issue_reg + 1'b1;
                    cmp_idx_next  = issue_reg;
                    cmp_pend_next = 1'b1;
                end
                else
                begin
                    cmp_pend_next = 1'b0;
                end
            end
        end
    end

    // table maintenance, limiter and verdict
    always_comb
    begin
        b4_valid_next = b4_valid_reg;
        b6_valid_next = b6_valid_reg;
        fill_next     = fill_reg;
        act_next      = act_reg;
        stat_next     = stat_reg;
        b4_we         = 1'b0;
        b6_we         = 1'b0;
        rt_we         = 1'b0;
        rt_waddr      = hit_idx_reg[RT_AW-1:0];
        rt_wdata      = {src4_reg, 32'd1, now_reg};
        if (cmd.plan)
        begin
            act_next  = (len_reg < ETH_MIN) ? ACT_ABORT : ACT_PASS;
            stat_next = ST_OK;
        end
        if (cmd.scan_finish && (table_reg != TBL_RT))
        begin
            case (req_reg) inside
                REQ_PACKET:
                begin
                    if (found_reg)
                    begin
                        act_next = ACT_DROP;
                    end
                end
                REQ_ADD4, REQ_ADD6:
                begin
                    if (!found_reg)
                    begin
                        if (free_found_reg)
                        begin
                            if (table_reg == TBL_B4)
                            begin
                                b4_we = 1'b1;
                                b4_valid_next[free_idx_reg[B4_AW-1:0]] = 1'b1;
                            end
                            else
                            begin
                                b6_we = 1'b1;
                                b6_valid_next[free_idx_reg[B6_AW-1:0]] = 1'b1;
                            end
                        end
                        else
                        begin
                            stat_next = ST_FULL;
                        end
                    end
                end
                default:
                begin
                    if (found_reg)
                    begin
                        if (table_reg == TBL_B4)
                        begin
                            b4_valid_next[hit_idx_reg[B4_AW-1:0]] = 1'b0;
                        end
                        else
                        begin
                            b6_valid_next[hit_idx_reg[B6_AW-1:0]] = 1'b0;
                        end
                    end
                    else
                    begin
                        stat_next = ST_NOTFOUND;
                    end
                end
            endcase
        end
        if (cmd.rate_update)
        begin
            if (found_reg)
            begin
                rt_we = 1'b1;
                if (in_win_reg)
                begin
                    rt_wdata = {src4_reg, inc_reg, hit_ws_reg};
                    if (inc_reg > rate_limit_reg)
                    begin
                        act_next = ACT_DROP;
                    end
                end
            end
            else if (fill_reg < RT_CW'(RATE_ENTRIES))
            begin
                rt_we     = 1'b1;
                rt_waddr  = fill_reg[RT_AW-1:0];
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    assign sel    = (req_reg == REQ_STATS) ? query_reg : act_reg;
    assign pk_sum = stp_reg[sel] + 64'd1;
    assign by_sum = stb_reg[sel] + ((act_reg != ACT_ABORT) ? 64'(len_reg) : 64'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_limit_reg <= 32'd0;
            window_reg     <= WINDOW_RESET;
            b4_valid_reg   <= '0;
            b6_valid_reg   <= '0;
            fill_reg       <= '0;
            for (int i = 0; i < 3; i++)
            begin
                stp_reg[i] <= 64'd0;
                stb_reg[i] <= 64'd0;
            end
            out_valid_reg  <= 1'b0;
            cmp_pend_reg   <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            table_reg      <= TBL_B4;
            issue_reg      <= '0;
            limit_reg      <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == CFG_RATE_LIMIT)
                begin
                    rate_limit_reg <= cfg_data[31:0];
                end
                else
                begin
                    window_reg <= cfg_data;
                end
            end
            b4_valid_reg   <= b4_valid_next;
            b6_valid_reg   <= b6_valid_next;
            fill_reg       <= fill_next;
            cmp_pend_reg   <= cmp_pend_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            table_reg      <= table_next;
            issue_reg      <= issue_next;
            limit_reg      <= limit_next;
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
                if (req_reg == REQ_PACKET)
                begin
                    stp_reg[act_reg] <= pk_sum;
                    stb_reg[act_reg] <= by_sum;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg   <= req_type;
            len_reg   <= frame_length;
            etype_reg <= ethertype;
            src4_reg  <= source_v4;
            hi_reg    <= source_v6_high;
            lo_reg    <= source_v6_low;
            now_reg   <= timestamp;
            query_reg <= query_action;
        end
        cmp_idx_reg  <= cmp_idx_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        hit_cnt_reg  <= hit_cnt_next;
        hit_ws_reg   <= hit_ws_next;
        act_reg      <= act_next;
        stat_reg     <= stat_next;
        if (cmd.rate_calc)
        begin
            in_win_reg <= ((now_reg - hit_ws_reg) < window_reg);
            inc_reg    <= (hit_cnt_reg == 32'hFFFF_FFFF) ? hit_cnt_reg : hit_cnt_reg + 32'd1;
        end
        if (cmd.commit)
        begin
            unique case (req_reg) inside
                REQ_PACKET:
                begin
                    verdict_reg <= act_reg;
                    status_reg  <= ST_OK;
                    pk_reg      <= pk_sum;
                    by_reg      <= by_sum;
                end
                REQ_STATS:
                begin
                    verdict_reg <= query_reg;
                    if (query_reg != ACT_NONE)
                    begin
                        status_reg <= ST_OK;
                        pk_reg     <= stp_reg[query_reg];
                        by_reg     <= stb_reg[query_reg];
                    end
                    else
                    begin
                        status_reg <= ST_NOTFOUND;
                        pk_reg     <= 64'd0;
                        by_reg     <= 64'd0;
                    end
                end
                REQ_ADD4, REQ_DEL4, REQ_ADD6, REQ_DEL6:
                begin
                    verdict_reg <= ACT_ABORT;
                    status_reg  <= stat_reg;
                    pk_reg      <= 64'd0;
                    by_reg      <= 64'd0;
                end
                default:
                begin
                    verdict_reg <= ACT_ABORT;
                    status_reg  <= ST_OK;
                    pk_reg      <= 64'd0;
                    by_reg      <= 64'd0;
                end
            endcase
        end
    end

    psf_ram #(.WIDTH(32), .DEPTH(BLOCK4_ENTRIES)) u_b4_ram (
        .clk   (clk),
        .we    (b4_we),
        .waddr (free_idx_reg[B4_AW-1:0]),
        .wdata (src4_reg),
        .raddr (issue_reg[B4_AW-1:0]),
        .rdata (b4_rdata)
    );

    psf_ram #(.WIDTH(128), .DEPTH(BLOCK6_ENTRIES)) u_b6_ram (
        .clk   (clk),
        .we    (b6_we),
        .waddr (free_idx_reg[B6_AW-1:0]),
        .wdata ({hi_reg, lo_reg}),
        .raddr (issue_reg[B6_AW-1:0]),
        .rdata (b6_rdata)
    );

    psf_ram #(.WIDTH(RT_DW), .DEPTH(RATE_ENTRIES)) u_rt_ram (
        .clk   (clk),
        .we    (rt_we),
        .waddr (rt_waddr),
        .wdata (rt_wdata),
        .raddr (issue_reg[RT_AW-1:0]),
        .rdata (rt_rdata)
    );

    assign out_valid      = out_valid_reg;
    assign verdict        = verdict_reg;
    assign status         = status_reg;
    assign action_packets = pk_reg;
    assign action_bytes   = by_reg;

endmodule

// ===== rtl/packet_source_filter_rate_limit.sv =====
// ----------------------------------------------------------------------------
// packet_source_filter_rate_limit
// Source blocklist filter with per-source fixed-window rate limiter.
// ----------------------------------------------------------------------------
// One request is processed at a time. Requests that need no table (short
// frames, non-IP packets, stats reads) go from accept through the plan
// state to commit, and the next request is taken back in idle.
// Table requests scan one entry per cycle through the table RAM read port:
// a v4 or v6 block lookup, add or remove reads up to BLOCK4_ENTRIES or
// BLOCK6_ENTRIES entries, stopping early on a hit; a long IPv4 packet
// not on the blocklist with limiting enabled adds a scan of the occupied
// rate entries and the rate calc and update states. A result held by a
// stalled output delays the next request. The rate table fills in arrival
// order and entries are never freed; no clearing pass is needed after reset.
module packet_source_filter_rate_limit
    import psf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  req_type,
    input  logic [15:0] frame_length,
    input  logic [15:0] ethertype,
    input  logic [31:0] source_v4,
    input  logic [63:0] source_v6_high,
    input  logic [63:0] source_v6_low,
    input  logic [63:0] timestamp,
    input  logic [1:0]  query_action,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  verdict,
    output logic [1:0]  status,
    output logic [63:0] action_packets,
    output logic [63:0] action_bytes,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);

    cmd_t  cmd;
    stat_t st;

    psf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    psf_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .req_type       (req_type),
        .frame_length   (frame_length),
        .ethertype      (ethertype),
        .source_v4      (source_v4),
        .source_v6_high (source_v6_high),
        .source_v6_low  (source_v6_low),
        .timestamp      (timestamp),
        .query_action   (query_action),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .verdict        (verdict),
        .status         (status),
        .action_packets (action_packets),
        .action_bytes   (action_bytes),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

endmodule
